// ===== sv/lacl_pkg.sv =====
// ----------------------------------------------------------------------------
// lacl_pkg
// Types, constants and codes shared by the listen ACL rule match unit.
// ----------------------------------------------------------------------------
`default_nettype none

package lacl_pkg;

    localparam int LACL_RULE_DEPTH = 16;

    localparam int ADDR_W      = 64;
    localparam int PORT_W      = 16;
    localparam int PROTO_W     = 2;
    localparam int INDEX_W     = 4;
    localparam int RCOUNT_W    = 5;
    localparam int V4_W        = 32;

    localparam int IN_DATA_W   = 184;
    localparam int OUT_DATA_W  = 8;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_CHECK = 1'b1;

    localparam logic REG_INSECURE   = 1'b0;
    localparam logic REG_RULE_COUNT = 1'b1;

    typedef struct packed {
        logic                op;
        logic [INDEX_W-1:0]  rule_index;
        logic [PROTO_W-1:0]  protocol;
        logic                is_v6;
        logic [ADDR_W-1:0]   addr_high;
        logic [ADDR_W-1:0]   addr_low;
        logic [PORT_W-1:0]   query_port;
        logic [PORT_W-1:0]   port_low;
        logic [PORT_W-1:0]   port_high;
        logic                ephemeral;
    } query_t;

    typedef struct packed {
        logic [ADDR_W-1:0]   addr_high;
        logic [ADDR_W-1:0]   addr_low;
        logic [PORT_W-1:0]   port_high;
        logic [PORT_W-1:0]   port_low;
        logic                ephemeral;
        logic                is_v6;
        logic [PROTO_W-1:0]  protocol;
    } rule_entry_t;

    typedef struct packed {
        logic load_query;
        logic write_rule;
        logic issue_read;
        logic out_load;
    } lacl_cmd_t;

    typedef struct packed {
        logic op_check;
        logic blocked;
        logic scan_empty;
        logic last_issue;
        logic out_busy;
    } lacl_status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_WRITE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } lacl_state_t;

endpackage

`default_nettype wire

// ===== sv/listen_acl_rule_match_unit.sv =====
// Sequence: a write runs DISPATCH, WRITE, FINISH; a check runs DISPATCH, SCAN
//   of n = min(rule_count, RULE_DEPTH) rules, DRAIN, FINISH (refused or n = 0:
//   DISPATCH, FINISH). One item at a time, one rule read per cycle in SCAN;
//   the next accept follows FINISH, which waits while a prior result stalls.
// Reset: rst_n clears control state and both registers; rule memory is
//   undefined until written and gets no clearing pass.
// ----------------------------------------------------------------------------
// listen_acl_rule_match_unit
// Listen ACL table: loads rules and checks listen requests against them.
// ----------------------------------------------------------------------------
`default_nettype none

module listen_acl_rule_match_unit
    import lacl_pkg::*;
#(
    parameter int RULE_DEPTH = LACL_RULE_DEPTH
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // rule_index, protocol, is_v6, addr_high, addr_low, query_port,
    // port_low, port_high, ephemeral_rule
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    // operation
    input  wire logic                  s_tuser,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // allowed, zero fill
    output logic      [OUT_DATA_W-1:0] m_tdata,
    // is_check_result
    output logic                       m_tuser
);

    logic                insecure_reg;
    logic [RCOUNT_W-1:0] rule_count_reg;
    logic                cfg_write;
    query_t              in_query;
    lacl_cmd_t           cmd;
    lacl_status_t        status;
    logic                out_allowed;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            insecure_reg   <= 1'b0;
            rule_count_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                REG_INSECURE:   insecure_reg   <= pwdata[0];
                REG_RULE_COUNT: rule_count_reg <= pwdata[RCOUNT_W-1:0];
                default:        insecure_reg   <= insecure_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_INSECURE:   prdata = {{(APB_DATA_W-1){1'b0}}, insecure_reg};
            REG_RULE_COUNT: prdata = {{(APB_DATA_W-RCOUNT_W){1'b0}}, rule_count_reg};
            default:        prdata = '0;
        endcase
    end

    assign in_query.op         = s_tuser;
    assign in_query.rule_index = s_tdata[3:0];
    assign in_query.protocol   = s_tdata[5:4];
    assign in_query.is_v6      = s_tdata[6];
    assign in_query.addr_high  = s_tdata[70:7];
    assign in_query.addr_low   = s_tdata[134:71];
    assign in_query.query_port = s_tdata[150:135];
    assign in_query.port_low   = s_tdata[166:151];
    assign in_query.port_high  = s_tdata[182:167];
    assign in_query.ephemeral  = s_tdata[183];

    lacl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    lacl_datapath #(
        .RULE_DEPTH (RULE_DEPTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_query     (in_query),
        .plaintext_en (insecure_reg),
        .rule_count   (rule_count_reg),
        .cmd          (cmd),
        .status       (status),
        .out_ready    (m_tready),
        .out_valid    (m_tvalid),
        .out_allowed  (out_allowed),
        .out_check    (m_tuser)
    );

    assign m_tdata = {{(OUT_DATA_W-1){1'b0}}, out_allowed};

endmodule

`default_nettype wire

// ===== sv/lacl_ctrl.sv =====
// ----------------------------------------------------------------------------
// lacl_ctrl
// Sequencer: takes one item, runs the rule write or the table scan, hands the
// result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lacl_ctrl
    import lacl_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire lacl_status_t status,
    output lacl_cmd_t         cmd
);

    lacl_state_t state_reg;
    lacl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                if (!status.op_check)
                begin
                    state_next = ST_WRITE;
                end
                else if (status.blocked || status.scan_empty)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_WRITE:
            begin
                state_next = ST_FINISH;
            end
            ST_SCAN:
            begin
                if (status.last_issue)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!status.out_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready       = 1'b1;
                cmd.load_query = in_valid;
            end
            ST_WRITE:
            begin
                cmd.write_rule = 1'b1;
            end
            ST_SCAN:
            begin
                cmd.issue_read = 1'b1;
            end
            ST_FINISH:
            begin
                cmd.out_load = !status.out_busy;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/lacl_datapath.sv =====
// ----------------------------------------------------------------------------
// lacl_datapath
// Rule memory, query register, scan counter, match compare and result
// register.
// ----------------------------------------------------------------------------
`default_nettype none

module lacl_datapath
    import lacl_pkg::*;
#(
    parameter int RULE_DEPTH = LACL_RULE_DEPTH
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire query_t              in_query,
    input  wire logic                plaintext_en,
    input  wire logic [RCOUNT_W-1:0] rule_count,
    input  wire lacl_cmd_t           cmd,
    output lacl_status_t             status,
    input  wire logic                out_ready,
    output logic                     out_valid,
    output logic                     out_allowed,
    output logic                     out_check
);

    localparam int IDX_W = (RULE_DEPTH > 1) ? $clog2(RULE_DEPTH) : 1;
    localparam int CNT_W = $clog2(RULE_DEPTH + 1);
    localparam int CMP_W = (CNT_W > RCOUNT_W) ? CNT_W : RCOUNT_W;

    rule_entry_t mem [RULE_DEPTH];

    query_t            query_reg;
    rule_entry_t       rd_data_reg;
    logic              rd_vld_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              hit_reg;
    logic              out_valid_reg;
    logic              out_allowed_reg;
    logic              out_check_reg;

    logic [CMP_W-1:0]  count_ext;
    logic [CMP_W-1:0]  depth_ext;
    logic [CMP_W-1:0]  index_ext;
    logic [CMP_W-1:0]  limit_ext;
    logic [CNT_W-1:0]  limit;
    logic [CNT_W:0]    cnt_plus;
    logic              index_ok;
    logic [IDX_W-1:0]  wr_addr;
    logic [IDX_W-1:0]  rd_addr;
    rule_entry_t       wr_entry;
    logic              match;
    logic              port_ok;
    logic              addr_ok;

    assign count_ext = CMP_W'(rule_count);
    assign depth_ext = CMP_W'(RULE_DEPTH);
    assign index_ext = CMP_W'(query_reg.rule_index);
    assign limit_ext = (count_ext > depth_ext) ? depth_ext : count_ext;
    assign limit     = CNT_W'(limit_ext);
    assign cnt_plus  = {1'b0, cnt_reg} + {{CNT_W{1'b0}}, 1'b1};
    assign index_ok  = (index_ext < depth_ext);
    assign wr_addr   = IDX_W'(index_ext);
    assign rd_addr   = cnt_reg[IDX_W-1:0];

    assign wr_entry.addr_high = query_reg.addr_high;
    assign wr_entry.addr_low  = query_reg.addr_low;
    assign wr_entry.port_high = query_reg.port_high;
    assign wr_entry.port_low  = query_reg.port_low;
    assign wr_entry.ephemeral = query_reg.ephemeral;
    assign wr_entry.is_v6     = query_reg.is_v6;
    assign wr_entry.protocol  = query_reg.protocol;

    // ephemeral rules only take port zero
    assign port_ok = rd_data_reg.ephemeral
                   ? (query_reg.query_port == '0)
                   : ((query_reg.query_port >= rd_data_reg.port_low)
                      && (query_reg.query_port <= rd_data_reg.port_high));

    // IPv4 compares the low 32 bits only
    assign addr_ok = query_reg.is_v6
                   ? ((rd_data_reg.addr_high == query_reg.addr_high)
                      && (rd_data_reg.addr_low == query_reg.addr_low))
                   : (rd_data_reg.addr_low[V4_W-1:0] == query_reg.addr_low[V4_W-1:0]);

    assign match = (rd_data_reg.protocol == query_reg.protocol)
                 && (rd_data_reg.is_v6 == query_reg.is_v6)
                 && port_ok && addr_ok;

    assign status.op_check   = (query_reg.op == OP_CHECK);
    assign status.blocked    = !query_reg.protocol[0] && !plaintext_en;
    assign status.scan_empty = (limit == '0);
    assign status.last_issue = (cnt_plus == {1'b0, limit});
    assign status.out_busy   = out_valid_reg && !out_ready;

    always_ff @(posedge clk)
    begin
        if (cmd.write_rule && index_ok)
        begin
            mem[wr_addr] <= wr_entry;
        end
        if (cmd.issue_read)
        begin
            rd_data_reg <= mem[rd_addr];
        end
        if (cmd.load_query)
        begin
            query_reg <= in_query;
        end
        if (cmd.out_load)
        begin
            out_allowed_reg <= hit_reg && (query_reg.op == OP_CHECK);
            out_check_reg   <= (query_reg.op == OP_CHECK);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_vld_reg    <= 1'b0;
            cnt_reg       <= '0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= cmd.issue_read;
            if (cmd.load_query)
            begin
                cnt_reg <= '0;
                hit_reg <= 1'b0;
            end
            else
            begin
                if (cmd.issue_read)
                begin
                    cnt_reg <= cnt_plus[CNT_W-1:0];
                end
                if (rd_vld_reg)
                begin
                    hit_reg <= hit_reg | match;
                end
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_allowed = out_allowed_reg;
    assign out_check   = out_check_reg;

endmodule

`default_nettype wire

// ===== sv/lacl_checker.sv =====
// ----------------------------------------------------------------------------
// lacl_checker
// Port-level checks for the listen ACL rule match unit, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module lacl_checker
    import lacl_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  pready,
    input wire logic                  s_tvalid,
    input wire logic                  s_tready,
    input wire logic                  m_tvalid,
    input wire logic                  m_tready,
    input wire logic [OUT_DATA_W-1:0] m_tdata,
    input wire logic                  m_tuser
);

    // a write acknowledge never reports allowed
    a_ack_not_allowed: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> !m_tdata[0])
        else $error("write acknowledge carries allowed");

    // one item at a time: no accept right after an accept
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted in back-to-back cycles");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[OUT_DATA_W-1:1] == '0))
        else $error("result padding not zero");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready low");

endmodule

bind listen_acl_rule_match_unit lacl_checker u_lacl_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
